### rtl/erc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants for the EMA regime classifier.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ALPHA_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int THR_W      = 31;
    localparam int BIAS_W     = 24;
    localparam int VOL_W      = 31;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ALPHA_W-1:0] VOL_GAIN_RST   = 17'd6554;
    localparam logic [ALPHA_W-1:0] MOM_ALPHA_RST  = 17'd6554;
    localparam logic [FRAC_W-1:0]  HYST_FRAC_RST  = 16'd6554;
    localparam logic [THR_W-1:0]   CRASH_THR_RST  = 31'd65536;
    localparam logic [THR_W-1:0]   TREND_THR_RST  = 31'd65536;
    localparam logic [BIAS_W-1:0]  BIAS_RST       = 24'd65536;

    typedef enum logic [1:0] {
        REGIME_RANGING  = 2'd0,
        REGIME_TRENDING = 2'd1,
        REGIME_CRASH    = 2'd2
    } regime_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOL_GAIN      = 3'd0,
        CFG_MOM_ALPHA     = 3'd1,
        CFG_HYST_FRAC     = 3'd2,
        CFG_CRASH_THR     = 3'd3,
        CFG_TREND_THR     = 3'd4,
        CFG_BIAS_RANGING  = 3'd5,
        CFG_BIAS_TRENDING = 3'd6,
        CFG_BIAS_CRASH    = 3'd7
    } cfg_index_t;

    // threshold settings handed to the classifier
    typedef struct packed {
        logic [FRAC_W-1:0] hyst_frac;
        logic [THR_W-1:0]  crash_thr;
        logic [THR_W-1:0]  trend_thr;
    } erc_thr_cfg_t;

    // classifier decision
    typedef struct packed {
        regime_t regime;
        logic    changed;
    } erc_cls_t;

endpackage

### rtl/erc_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_filter
// One update of the volatility and momentum averages: avg += (a*(x-avg))>>>16.
// ----------------------------------------------------------------------------
module erc_filter import erc_pkg::*; (
    input  logic [ALPHA_W-1:0]         vol_gain,
    input  logic [ALPHA_W-1:0]         mom_alpha,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] last_sample,
    input  logic [VOL_W-1:0]           vol_avg,
    input  logic signed [SAMPLE_W-1:0] mom_avg,
    output logic [VOL_W-1:0]           vol_new,
    output logic signed [SAMPLE_W-1:0] mom_new
);

    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic signed [33:0] vol_err;
    logic signed [51:0] vol_prod;
    logic signed [35:0] vol_shift;
    logic signed [36:0] vol_sum;
    logic signed [32:0] mom_err;
    logic signed [50:0] mom_prod;
    logic signed [34:0] mom_shift;
    logic signed [35:0] mom_sum;

    // volatility: |x - previous|, saturated to 0 .. 2^31-1
    assign diff      = {sample[31], sample} - {last_sample[31], last_sample};
    assign abs_diff  = diff[32] ? 33'(-diff) : 33'(diff);
    assign vol_err   = $signed({1'b0, abs_diff}) - $signed({3'b000, vol_avg});
    assign vol_prod  = $signed({1'b0, vol_gain}) * vol_err;
    assign vol_shift = vol_prod[51:16];
    assign vol_sum   = {vol_shift[35], vol_shift} + $signed({6'b0, vol_avg});

    always_comb begin
        if (vol_sum[36]) begin
            vol_new = '0;
        end else if (|vol_sum[35:31]) begin
            vol_new = '1;
        end else begin
            vol_new = vol_sum[30:0];
        end
    end

    // momentum: saturates only when alpha overshoots
    assign mom_err   = {sample[31], sample} - {mom_avg[31], mom_avg};
    assign mom_prod  = $signed({1'b0, mom_alpha}) * mom_err;
    assign mom_shift = mom_prod[50:16];
    assign mom_sum   = {mom_shift[34], mom_shift} + {{4{mom_avg[31]}}, mom_avg};

    always_comb begin
        if (mom_sum[35:31] == 5'b00000 || mom_sum[35:31] == 5'b11111) begin
            mom_new = mom_sum[31:0];
        end else if (mom_sum[35]) begin
            mom_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            mom_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

endmodule

### rtl/erc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_classify
// Hysteresis regime decision; exit thresholds kept in registers.
// ----------------------------------------------------------------------------
module erc_classify import erc_pkg::*; (
    input  logic                       aclk,
    input  erc_thr_cfg_t               thr_cfg,
    input  regime_t                    cur_regime,
    input  logic [VOL_W-1:0]           vol_avg,
    input  logic signed [SAMPLE_W-1:0] mom_avg,
    output erc_cls_t                   cls
);

    logic [FRAC_W:0]         keep;
    logic [THR_W+FRAC_W:0]   crash_prod;
    logic [THR_W+FRAC_W:0]   trend_prod;
    logic [THR_W-1:0]        crash_lo_reg;
    logic [THR_W-1:0]        trend_lo_reg;
    logic [THR_W-1:0]        crash_lo_next;
    logic [THR_W-1:0]        trend_lo_next;
    logic [SAMPLE_W-1:0]     mag;
    logic                    crash_hit;
    logic                    trend_hit;

    // lo(t) = t*(65536-h) >> 16, never above t
    assign keep          = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, thr_cfg.hyst_frac};
    assign crash_prod    = thr_cfg.crash_thr * keep;
    assign trend_prod    = thr_cfg.trend_thr * keep;
    assign crash_lo_next = crash_prod[THR_W+FRAC_W-1:FRAC_W];
    assign trend_lo_next = trend_prod[THR_W+FRAC_W-1:FRAC_W];

    always_ff @(posedge aclk) begin
        crash_lo_reg <= crash_lo_next;
        trend_lo_reg <= trend_lo_next;
    end

    assign mag = mom_avg[SAMPLE_W-1] ? SAMPLE_W'(-mom_avg) : SAMPLE_W'(mom_avg);

    always_comb begin
        if (cur_regime == REGIME_CRASH) begin
            crash_hit = (vol_avg >= crash_lo_reg);
        end else begin
            crash_hit = (vol_avg >= thr_cfg.crash_thr);
        end
        if (cur_regime == REGIME_TRENDING) begin
            trend_hit = (mag > {1'b0, trend_lo_reg});
        end else begin
            trend_hit = (mag > {1'b0, thr_cfg.trend_thr});
        end
        if (crash_hit) begin
            cls.regime = REGIME_CRASH;
        end else if (trend_hit) begin
            cls.regime = REGIME_TRENDING;
        end else begin
            cls.regime = REGIME_RANGING;
        end
        cls.changed = (cls.regime != cur_regime);
    end

endmodule

### rtl/ema_regime_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_regime_classifier_unit
// Market regime classifier over signed Q16.16 return samples.
//
// Usage:
//   s_ channel carries one request: s_command (0 feed sample, 1 clear) and
//   s_return_value. Every request gives exactly one result on the m_ channel:
//   regime, change flag, previous regime, bias of the current regime, both
//   averages after the update and the wrapping change count.
//   A request in the input register is presented on m_ once it moves to the
//   result register. Throughput: one request per cycle while m_ready is high.
//   Input register -> filter multiply, add, saturate, hysteresis compare ->
//   result register; the state registers load at the same edge as the result.
//   The first sample after reset or clear only seeds the previous value.
//   When m_ready is low the result register holds; the input register takes
//   one more request, then s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   filter state and restores register defaults. Configuration writes
//   (cfg_we/cfg_index/cfg_wdata) are for idle periods; the hysteresis exit
//   levels follow a threshold write in the cycle after it.
// ----------------------------------------------------------------------------
module ema_regime_classifier_unit import erc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic signed [SAMPLE_W-1:0] s_return_value,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_regime,
    output logic                       m_regime_changed,
    output logic [1:0]                 m_previous_regime,
    output logic [BIAS_W-1:0]          m_bias_factor,
    output logic [VOL_W-1:0]           m_volatility_avg,
    output logic signed [SAMPLE_W-1:0] m_momentum_avg,
    output logic [COUNT_W-1:0]         m_change_count
);

    // configuration registers
    logic [ALPHA_W-1:0] vol_gain_reg;
    logic [ALPHA_W-1:0] mom_alpha_reg;
    logic [FRAC_W-1:0]  hyst_frac_reg;
    logic [THR_W-1:0]   crash_thr_reg;
    logic [THR_W-1:0]   trend_thr_reg;
    logic [BIAS_W-1:0]  bias_rng_reg;
    logic [BIAS_W-1:0]  bias_trd_reg;
    logic [BIAS_W-1:0]  bias_crs_reg;

    // input register
    logic                       in_valid_reg, in_valid_next;
    logic                       in_command_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;

    // filter and classifier state
    logic signed [SAMPLE_W-1:0] last_sample_reg, last_sample_next;
    logic                       seeded_reg, seeded_next;
    logic [VOL_W-1:0]           vol_avg_reg, vol_avg_next;
    logic signed [SAMPLE_W-1:0] mom_avg_reg, mom_avg_next;
    regime_t                    regime_reg, regime_next;
    logic [COUNT_W-1:0]         change_cnt_reg, change_cnt_next;

    // result register
    logic                       m_valid_reg, m_valid_next;
    regime_t                    m_regime_reg, m_regime_next;
    logic                       m_changed_reg, m_changed_next;
    regime_t                    m_prev_reg, m_prev_next;
    logic [BIAS_W-1:0]          m_bias_reg;
    logic [VOL_W-1:0]           m_vol_reg, m_vol_next;
    logic signed [SAMPLE_W-1:0] m_mom_reg, m_mom_next;
    logic [COUNT_W-1:0]         m_count_reg, m_count_next;

    logic                       advance;
    logic [VOL_W-1:0]           vol_new;
    logic signed [SAMPLE_W-1:0] mom_new;
    erc_thr_cfg_t               thr_cfg;
    erc_cls_t                   cls;
    logic [BIAS_W-1:0]          bias_val;

    // ---------------------------------------------------------------- datapath
    erc_filter u_filter (
        .vol_gain    (vol_gain_reg),
        .mom_alpha   (mom_alpha_reg),
        .sample      (in_sample_reg),
        .last_sample (last_sample_reg),
        .vol_avg     (vol_avg_reg),
        .mom_avg     (mom_avg_reg),
        .vol_new     (vol_new),
        .mom_new     (mom_new)
    );

    assign thr_cfg.hyst_frac = hyst_frac_reg;
    assign thr_cfg.crash_thr = crash_thr_reg;
    assign thr_cfg.trend_thr = trend_thr_reg;

    erc_classify u_classify (
        .aclk       (aclk),
        .thr_cfg    (thr_cfg),
        .cur_regime (regime_reg),
        .vol_avg    (vol_new),
        .mom_avg    (mom_new),
        .cls        (cls)
    );

    // --------------------------------------------------------------- handshake
    // the request in the input register moves on when the result slot is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // bias for the regime that the result reports
    always_comb begin
        case (regime_next)
            REGIME_TRENDING: bias_val = bias_trd_reg;
            REGIME_CRASH:    bias_val = bias_crs_reg;
            default:         bias_val = bias_rng_reg;
        endcase
    end

    always_comb begin
        in_valid_next    = in_valid_reg;
        m_valid_next     = m_valid_reg;
        last_sample_next = last_sample_reg;
        seeded_next      = seeded_reg;
        vol_avg_next     = vol_avg_reg;
        mom_avg_next     = mom_avg_reg;
        regime_next      = regime_reg;
        change_cnt_next  = change_cnt_reg;
        m_regime_next    = m_regime_reg;
        m_changed_next   = m_changed_reg;
        m_prev_next      = m_prev_reg;
        m_vol_next       = m_vol_reg;
        m_mom_next       = m_mom_reg;
        m_count_next     = m_count_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (advance) begin
            if (in_command_reg) begin
                // clear: state back to reset, registers untouched
                last_sample_next = '0;
                seeded_next      = 1'b0;
                vol_avg_next     = '0;
                mom_avg_next     = '0;
                regime_next      = REGIME_RANGING;
                change_cnt_next  = '0;
                m_prev_next      = REGIME_RANGING;
                m_changed_next   = 1'b0;
            end else if (!seeded_reg) begin
                // first sample only seeds the previous value
                last_sample_next = in_sample_reg;
                seeded_next      = 1'b1;
                m_prev_next      = regime_reg;
                m_changed_next   = 1'b0;
            end else begin
                last_sample_next = in_sample_reg;
                vol_avg_next     = vol_new;
                mom_avg_next     = mom_new;
                regime_next      = cls.regime;
                change_cnt_next  = change_cnt_reg + COUNT_W'(cls.changed);
                m_prev_next      = regime_reg;
                m_changed_next   = cls.changed;
            end
            m_regime_next = regime_next;
            m_vol_next    = vol_avg_next;
            m_mom_next    = mom_avg_next;
            m_count_next  = change_cnt_next;
        end
    end

    // --------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_gain_reg  <= VOL_GAIN_RST;
            mom_alpha_reg <= MOM_ALPHA_RST;
            hyst_frac_reg <= HYST_FRAC_RST;
            crash_thr_reg <= CRASH_THR_RST;
            trend_thr_reg <= TREND_THR_RST;
            bias_rng_reg  <= BIAS_RST;
            bias_trd_reg  <= BIAS_RST;
            bias_crs_reg  <= BIAS_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_VOL_GAIN:      vol_gain_reg  <= cfg_wdata[ALPHA_W-1:0];
                CFG_MOM_ALPHA:     mom_alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                CFG_HYST_FRAC:     hyst_frac_reg <= cfg_wdata[FRAC_W-1:0];
                CFG_CRASH_THR:     crash_thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_TREND_THR:     trend_thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_BIAS_RANGING:  bias_rng_reg  <= cfg_wdata[BIAS_W-1:0];
                CFG_BIAS_TRENDING: bias_trd_reg  <= cfg_wdata[BIAS_W-1:0];
                CFG_BIAS_CRASH:    bias_crs_reg  <= cfg_wdata[BIAS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            last_sample_reg <= '0;
            seeded_reg      <= 1'b0;
            vol_avg_reg     <= '0;
            mom_avg_reg     <= '0;
            regime_reg      <= REGIME_RANGING;
            change_cnt_reg  <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            m_valid_reg     <= m_valid_next;
            last_sample_reg <= last_sample_next;
            seeded_reg      <= seeded_next;
            vol_avg_reg     <= vol_avg_next;
            mom_avg_reg     <= mom_avg_next;
            regime_reg      <= regime_next;
            change_cnt_reg  <= change_cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_sample_reg  <= s_return_value;
        end
        if (advance) begin
            m_bias_reg <= bias_val;
        end
        m_regime_reg  <= m_regime_next;
        m_changed_reg <= m_changed_next;
        m_prev_reg    <= m_prev_next;
        m_vol_reg     <= m_vol_next;
        m_mom_reg     <= m_mom_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_regime          = m_regime_reg;
    assign m_regime_changed  = m_changed_reg;
    assign m_previous_regime = m_prev_reg;
    assign m_bias_factor     = m_bias_reg;
    assign m_volatility_avg  = m_vol_reg;
    assign m_momentum_avg    = m_mom_reg;
    assign m_change_count    = m_count_reg;

    // -------------------------------------------------------------- assertions
    // an empty result slot never stalls the request side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("s_ready low with empty result register");

    // a reported change always differs from the previous regime
    a_change_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_changed_reg |-> m_regime_reg != m_prev_reg)
        else $error("regime change flagged without a new regime");

    // a clear request reports the cleared state
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_command_reg |=>
            m_count_reg == '0 && m_regime_reg == REGIME_RANGING && !m_changed_reg)
        else $error("clear request did not report cleared state");

    // the count moves by exactly the change flag on a sample
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_command_reg |=>
            change_cnt_reg == $past(change_cnt_reg) + COUNT_W'(m_changed_reg))
        else $error("change count out of step with change flag");

    // a seeding sample never changes the regime
    a_seed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_command_reg && !seeded_reg |=> !m_changed_reg && seeded_reg)
        else $error("seeding sample changed the regime");

endmodule

### verif/ema_regime_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ema_regime_classifier_unit_tb
// Self-checking bench for the EMA regime classifier. A clocked driver sends
// requests from a pending queue, and a clocked monitor takes results. Each
// accepted request runs through a local fixed-point predictor, which covers
// filter update, saturation, hysteresis and change count. The bench compares
// the predicted result field by field with the one that the block returns.
// Register settings change between phases, with the block idle.
// ----------------------------------------------------------------------------
module ema_regime_classifier_unit_tb;
    import erc_pkg::*;

    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam longint VOL_CEIL  = 64'sd2147483647;
    localparam longint MOM_CEIL  = 64'sd2147483647;
    localparam longint MOM_FLOOR = -64'sd2147483648;

    // receiver back-pressure burst and no-progress limit, in cycles
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    // one request as queued for the driver; paced selects random gaps
    typedef struct {
        logic        command;
        logic [31:0] value;
        bit          paced;
    } request_t;

    // predicted result, paced is carried along for the receiver side
    typedef struct {
        regime_t           regime;
        logic              changed;
        regime_t           prev;
        logic [BIAS_W-1:0] bias;
        logic [VOL_W-1:0]  vol;
        logic [31:0]       mom;
        logic [31:0]       count;
        bit                paced;
    } regime_result_t;

    // ------------------------------------------------------------------
    // clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                       aclk;
    logic                       aresetn        = 1'b0;
    logic                       cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata      = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic                       s_command      = CMD_FEED;
    logic signed [SAMPLE_W-1:0] s_return_value = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic [1:0]                 m_regime;
    logic                       m_regime_changed;
    logic [1:0]                 m_previous_regime;
    logic [BIAS_W-1:0]          m_bias_factor;
    logic [VOL_W-1:0]           m_volatility_avg;
    logic signed [SAMPLE_W-1:0] m_momentum_avg;
    logic [COUNT_W-1:0]         m_change_count;

    ema_regime_classifier_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_return_value    (s_return_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_regime          (m_regime),
        .m_regime_changed  (m_regime_changed),
        .m_previous_regime (m_previous_regime),
        .m_bias_factor     (m_bias_factor),
        .m_volatility_avg  (m_volatility_avg),
        .m_momentum_avg    (m_momentum_avg),
        .m_change_count    (m_change_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // register mirror, kept in step with every write on the cfg port
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0] vol_gain_r      = VOL_GAIN_RST;
    logic [ALPHA_W-1:0] mom_alpha_r     = MOM_ALPHA_RST;
    logic [FRAC_W-1:0]  hyst_frac_r     = HYST_FRAC_RST;
    logic [THR_W-1:0]   crash_thr_r     = CRASH_THR_RST;
    logic [THR_W-1:0]   trend_thr_r     = TREND_THR_RST;
    logic [BIAS_W-1:0]  bias_ranging_r  = BIAS_RST;
    logic [BIAS_W-1:0]  bias_trending_r = BIAS_RST;
    logic [BIAS_W-1:0]  bias_crash_r    = BIAS_RST;

    // predictor state: wide signed values so the saturation is explicit
    longint      last_ret     = 0;
    bit          seeded       = 1'b0;
    longint      vol_avg      = 0;
    longint      mom_avg      = 0;
    regime_t     cur_regime   = REGIME_RANGING;
    logic [31:0] change_total = '0;

    request_t       pending_requests[$];
    regime_result_t expected_results[$];

    request_t       cur_req;
    regime_result_t exp_res;
    int             send_wait      = 0;
    int             rx_wait        = 0;
    int             hold_left      = 0;
    int             results_seen   = 0;
    int             mismatch_count = 0;
    int             stall_cycles   = 0;

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the classifier by one request and return the result it gives.
    function automatic regime_result_t advance_classifier(request_t req);
        regime_result_t r;
        longint         x;
        longint         d;
        longint         ad;
        longint         mag;
        longint         lo_crash;
        longint         lo_trend;
        regime_t        prev_reg;
        regime_t        cand;
        logic           chg;

        prev_reg = cur_regime;
        chg      = 1'b0;
        if (req.command == CMD_CLEAR) begin
            // filters, regime and count go back to reset; registers stay
            last_ret     = 0;
            seeded       = 1'b0;
            vol_avg      = 0;
            mom_avg      = 0;
            cur_regime   = REGIME_RANGING;
            change_total = '0;
            prev_reg     = REGIME_RANGING;
        end else if (!seeded) begin
            // first sample only primes the previous value
            last_ret = longint'(signed'(req.value));
            seeded   = 1'b1;
        end else begin
            x  = longint'(signed'(req.value));
            d  = x - last_ret;
            ad = (d < 0) ? -d : d;
            // >>> on a signed longint is the floor shift the filter uses
            vol_avg = saturate(vol_avg + ((longint'(vol_gain_r) * (ad - vol_avg)) >>> 16),
                               0, VOL_CEIL);
            mom_avg = saturate(mom_avg + ((longint'(mom_alpha_r) * (x - mom_avg)) >>> 16),
                               MOM_FLOOR, MOM_CEIL);
            last_ret = x;

            // exit levels shrink each threshold by the hysteresis fraction
            lo_crash = (longint'(crash_thr_r) * (65536 - longint'(hyst_frac_r))) >>> 16;
            lo_trend = (longint'(trend_thr_r) * (65536 - longint'(hyst_frac_r))) >>> 16;
            mag      = (mom_avg < 0) ? -mom_avg : mom_avg;

            cand = REGIME_RANGING;
            if ((cur_regime == REGIME_TRENDING) ? (mag > lo_trend)
                                                : (mag > longint'(trend_thr_r)))
                cand = REGIME_TRENDING;
            // crash outranks trending
            if ((cur_regime == REGIME_CRASH) ? (vol_avg >= lo_crash)
                                             : (vol_avg >= longint'(crash_thr_r)))
                cand = REGIME_CRASH;

            if (cand != cur_regime) begin
                cur_regime   = cand;
                change_total = change_total + 32'd1;
                chg          = 1'b1;
            end
        end

        r.regime  = cur_regime;
        r.changed = chg;
        r.prev    = prev_reg;
        case (cur_regime)
            REGIME_TRENDING: r.bias = bias_trending_r;
            REGIME_CRASH:    r.bias = bias_crash_r;
            default:         r.bias = bias_ranging_r;
        endcase
        r.vol   = vol_avg[VOL_W-1:0];
        r.mom   = mom_avg[31:0];
        r.count = change_total;
        r.paced = req.paced;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers the next pending request once the last one is taken,
    // after a random gap for paced requests. Prediction is
    // done at the accepting edge so the queue order matches the block.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_classifier(cur_req));
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req         = pending_requests.pop_front();
                    s_valid        <= 1'b1;
                    s_command      <= cur_req.command;
                    s_return_value <= cur_req.value;
                    send_wait       = cur_req.paced ? $urandom_range(0, 3) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: checks each taken result against the oldest prediction,
    // then idles for a random gap. Twice in the run it holds m_ready low for a
    // long burst while the driver keeps offering, so the block backs up
    // and drops s_ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_seen == 250 || results_seen == 1000)
                    hold_left = LONG_HOLD;
                if (expected_results.size() == 0) begin
                    $display("%0t: result expected none actual regime %0d count 0x%0h",
                             $time, m_regime, m_change_count);
                    mismatch_count++;
                    rx_wait = 0;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("regime", exp_res.regime, m_regime);
                    check_field("regime_changed", exp_res.changed, m_regime_changed);
                    check_field("previous_regime", exp_res.prev, m_previous_regime);
                    check_field("bias_factor", exp_res.bias, m_bias_factor);
                    check_field("volatility_avg", exp_res.vol, m_volatility_avg);
                    check_field("momentum_avg", exp_res.mom, m_momentum_avg);
                    check_field("change_count", exp_res.count, m_change_count);
                    rx_wait = exp_res.paced ? $urandom_range(0, 3) : 0;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: no handshake on either side for too long ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_request(logic cmd, logic [31:0] value, bit paced);
        request_t r;
        r.command = cmd;
        r.value   = value;
        r.paced   = paced;
        pending_requests.push_back(r);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_VOL_GAIN:      vol_gain_r      = value[ALPHA_W-1:0];
            CFG_MOM_ALPHA:     mom_alpha_r     = value[ALPHA_W-1:0];
            CFG_HYST_FRAC:     hyst_frac_r     = value[FRAC_W-1:0];
            CFG_CRASH_THR:     crash_thr_r     = value[THR_W-1:0];
            CFG_TREND_THR:     trend_thr_r     = value[THR_W-1:0];
            CFG_BIAS_RANGING:  bias_ranging_r  = value[BIAS_W-1:0];
            CFG_BIAS_TRENDING: bias_trending_r = value[BIAS_W-1:0];
            default:           bias_crash_r    = value[BIAS_W-1:0];
        endcase
    endtask

    // full register set; the extra cycles let the exit levels catch up
    task automatic apply_setting(int unsigned va, int unsigned ma, int unsigned hf,
                                 int unsigned ct, int unsigned tt,
                                 int unsigned br, int unsigned bt, int unsigned bc);
        write_reg(CFG_VOL_GAIN, va);
        write_reg(CFG_MOM_ALPHA, ma);
        write_reg(CFG_HYST_FRAC, hf);
        write_reg(CFG_CRASH_THR, ct);
        write_reg(CFG_TREND_THR, tt);
        write_reg(CFG_BIAS_RANGING, br);
        write_reg(CFG_BIAS_TRENDING, bt);
        write_reg(CFG_BIAS_CRASH, bc);
        repeat (3) @(posedge aclk);
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // Random stretches shaped like market behavior around the given scale:
    // calm noise, steady trends, violent swings, raw 32-bit noise and the
    // odd clear, so the classifier walks through all its transitions.
    task automatic fill_random(int n_items, int unsigned scale);
        int          made;
        int          len;
        int          pat;
        int          k;
        bit          paced;
        longint      v;
        longint      base;
        int unsigned m;

        made = 0;
        while (made < n_items) begin
            pat   = $urandom_range(0, 9);
            len   = (pat == 9) ? 1 : $urandom_range(4, 24);
            paced = ($urandom_range(0, 3) != 0);
            base  = longint'(scale) * $urandom_range(1, 6);
            if ($urandom_range(0, 1) != 0)
                base = -base;
            for (k = 0; k < len; k++) begin
                case (pat)
                    0, 1, 2: begin
                        m = scale / 4;
                        v = longint'($urandom_range(0, 2 * m)) - m;
                    end
                    3, 4: begin
                        m = scale / 8;
                        v = base + longint'($urandom_range(0, 2 * m)) - m;
                    end
                    5, 6: begin
                        v = longint'(scale) * $urandom_range(1, 8);
                        if (k % 2 != 0)
                            v = -v;
                    end
                    7, 8: v = longint'($urandom());
                    default: v = 0;
                endcase
                if (pat == 9)
                    push_request(CMD_CLEAR, $urandom(), paced);
                else
                    push_request(CMD_FEED, v[31:0], paced);
            end
            made += len;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset defaults: seed at the top of the range, then a
        // full-scale jump into crash, small moves, a clear and a steady
        // climb into trending
        @(negedge aclk);
        push_request(CMD_FEED, 32'h7FFF_FFFF, 1'b1);
        push_request(CMD_FEED, 32'h8000_0000, 1'b1);
        push_request(CMD_FEED, 32'h0000_0000, 1'b1);
        push_request(CMD_FEED, 32'h0000_0001, 1'b1);
        push_request(CMD_FEED, 32'hFFFF_FFFF, 1'b1);
        push_request(CMD_CLEAR, 32'hA5A5_A5A5, 1'b1);
        push_request(CMD_FEED, 32'h0000_0000, 1'b1);
        repeat (5) push_request(CMD_FEED, 32'h0003_0000, 1'b1);
        push_request(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // directed, overshooting filters and widest exit band: volatility
        // and momentum both saturate, then volatility clamps at zero
        apply_setting(17'h1FFFF, 17'h1FFFF, 16'hFFFF, 31'h7FFF_FFFF, 0,
                      24'hFFFFFF, 0, 24'h123456);
        @(negedge aclk);
        push_request(CMD_FEED, 32'h0000_0000, 1'b1);
        push_request(CMD_FEED, 32'h7FFF_FFFF, 1'b1);
        push_request(CMD_FEED, 32'h8000_0000, 1'b1);
        push_request(CMD_FEED, 32'h8000_0000, 1'b1);
        push_request(CMD_FEED, 32'h0000_0010, 1'b1);
        push_request(CMD_CLEAR, 32'h0000_0000, 1'b1);
        wait_drained();

        // directed, frozen filters and zero thresholds: crash at once
        apply_setting(0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0);
        @(negedge aclk);
        push_request(CMD_FEED, 32'h0000_0005, 1'b1);
        push_request(CMD_FEED, 32'h0000_0007, 1'b1);
        push_request(CMD_FEED, 32'hFFFF_FFF7, 1'b1);
        push_request(CMD_CLEAR, 32'h5A5A_5A5A, 1'b1);
        wait_drained();

        // random phases, each under its own register setting
        apply_setting(VOL_GAIN_RST, MOM_ALPHA_RST, HYST_FRAC_RST, CRASH_THR_RST,
                      TREND_THR_RST, BIAS_RST, BIAS_RST, BIAS_RST);
        @(negedge aclk);
        fill_random(210, 32'h0001_0000);
        wait_drained();

        // unity smoothing, no hysteresis
        apply_setting(17'h10000, 17'h10000, 0, 31'h0004_0000, 31'h0002_0000,
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF));
        @(negedge aclk);
        fill_random(210, 32'h0002_0000);
        wait_drained();

        // every register at its top value
        apply_setting(17'h1FFFF, 17'h1FFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        @(negedge aclk);
        fill_random(210, 32'h1000_0000);
        wait_drained();

        // typical smoothing with thresholds in reach of the samples
        apply_setting($urandom_range(1000, 40000), $urandom_range(1000, 40000),
                      $urandom_range(0, 32768), 31'h0008_0000, 31'h0004_0000,
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF));
        @(negedge aclk);
        fill_random(210, 32'h0004_0000);
        wait_drained();

        // zero smoothing, half-width exit band
        apply_setting(0, 0, 16'h8000, 0, 0, 24'h000001, 24'h800000, 24'h7FFFFF);
        @(negedge aclk);
        fill_random(180, 32'h0001_0000);
        wait_drained();

        // registers anywhere in their range
        apply_setting($urandom_range(0, 17'h1FFFF), $urandom_range(0, 17'h1FFFF),
                      $urandom_range(0, 16'hFFFF), $urandom_range(0, 31'h7FFF_FFFF),
                      $urandom_range(0, 31'h7FFF_FFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
        @(negedge aclk);
        fill_random(210, 32'h0100_0000);
        wait_drained();

        // slow filters with small, mostly reachable thresholds
        apply_setting($urandom_range(100, 8000), $urandom_range(100, 8000),
                      $urandom_range(0, 16'hFFFF), $urandom_range(16'h4000, 31'h0004_0000),
                      $urandom_range(16'h4000, 31'h0004_0000), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
        @(negedge aclk);
        fill_random(220, 32'h0002_0000);
        wait_drained();

        // let any stray result surface before the verdict
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/erc_pkg.sv
rtl/erc_filter.sv
rtl/erc_classify.sv
rtl/ema_regime_classifier_unit.sv
verif/ema_regime_classifier_unit_tb.sv
